FILE: design/mt64_pkg.sv
// Shared constants, codes and controller/datapath types for the MT19937-64 generator.
package mt64_pkg;

  localparam int WORD_W       = 64;
  localparam int STATE_WORDS  = 312;
  localparam int TWIST_OFFSET = 156;
  localparam int ADDR_W       = $clog2(STATE_WORDS + 1);
  localparam int HALF_W       = WORD_W / 2;

  localparam logic [WORD_W-1:0] MATRIX_A      = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] UPPER_BITS    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [WORD_W-1:0] LOWER_BITS    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_MULT     = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] FALLBACK_SEED = 64'd5489;
  localparam logic [WORD_W-1:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_SEED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_M0,
    ST_SEED_M1,
    ST_SEED_M2,
    ST_SEED_WR,
    ST_DRAW_CHECK,
    ST_TWIST_PRE,
    ST_TWIST_RD,
    ST_TWIST_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_t;

  typedef enum logic [1:0] {K_HOLD, K_ZERO, K_ONE, K_INC} kop_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_SPENT, IDX_ZERO, IDX_INC} idxop_t;
  typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_HL, MUL_LH} mulop_t;
  typedef enum logic [1:0] {RD_NONE, RD_K, RD_TWIST, RD_INDEX} rdsel_t;
  typedef enum logic [1:0] {WR_NONE, WR_SEED0, WR_SEEDK, WR_TWIST} wrsel_t;

  typedef struct packed {
    logic   capture;
    logic   use_default;
    kop_t   kop;
    idxop_t idxop;
    mulop_t mulop;
    rdsel_t rdsel;
    wrsel_t wrsel;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic index_spent;
    logic out_free;
  } status_t;

endpackage

FILE: design/mt64_if.sv
// Valid/ready channel interfaces for items, results and the configuration register.
interface mt64_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [mt64_pkg::WORD_W-1:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink (input valid, input func, input seed_value, output ready);
endinterface

interface mt64_out_if;
  logic                        valid;
  logic                        ready;
  logic [mt64_pkg::WORD_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

interface mt64_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mt64_pkg::WORD_W-1:0] default_seed;

  modport source (output valid, output default_seed, input ready);
  modport sink (input valid, input default_seed, output ready);
endinterface

FILE: design/mt19937_64_generator.sv
// Top level of the MT19937-64 generator: controller joined to the datapath.
// Items arrive one at a time; the block takes a new item only when the previous one is
// finished, while a delivered result may still wait in the output register. A draw checks
// the index, reads the word and loads it tempered into the output register, waiting while
// that register is full. A draw that finds all 312 words used first twists the state. A seed
// item refills the state word by word (one 32x32 partial product per cycle of the 64-bit seed
// multiply); a draw before any seed does this first from default_seed, written through cfg,
// always ready. Write default_seed only while idle; the block does not enforce this.
module mt19937_64_generator (
  input  logic       clk,
  input  logic       rst,
  mt64_in_if.sink    item,
  mt64_out_if.source result,
  mt64_cfg_if.sink   cfg
);
  import mt64_pkg::*;

  cmd_t    cmd;
  status_t status;

  mt64_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  mt64_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .seed_value (item.seed_value),
    .cmd        (cmd),
    .status     (status),
    .result     (result),
    .cfg        (cfg)
  );

endmodule

FILE: design/mt64_ctrl.sv
// Sequencing state machine for seeding, twisting and drawing.
module mt64_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_func,
  output logic              item_ready,
  input  mt64_pkg::status_t status,
  output mt64_pkg::cmd_t    cmd
);
  import mt64_pkg::*;

  state_t state, state_next;
  logic   seeded, seeded_next;
  logic   pending, pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      seeded  <= 1'b0;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      seeded  <= seeded_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    state_next      = state;
    seeded_next     = seeded;
    pending_next    = pending;
    item_ready      = 1'b0;
    cmd.capture     = 1'b0;
    cmd.use_default = 1'b0;
    cmd.kop         = K_HOLD;
    cmd.idxop       = IDX_HOLD;
    cmd.mulop       = MUL_NONE;
    cmd.rdsel       = RD_NONE;
    cmd.wrsel       = WR_NONE;
    cmd.out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture  = 1'b1;
          pending_next = (item_func == FUNC_DRAW);
          if (item_func == FUNC_SEED || !seeded) begin
            state_next = ST_SEED_INIT;
          end else begin
            state_next = ST_DRAW_CHECK;
          end
        end
      end
      ST_SEED_INIT: begin
        cmd.use_default = pending;
        cmd.wrsel       = WR_SEED0;
        cmd.kop         = K_ONE;
        state_next      = ST_SEED_M0;
      end
      ST_SEED_M0: begin
        cmd.mulop  = MUL_LL;
        state_next = ST_SEED_M1;
      end
      ST_SEED_M1: begin
        cmd.mulop  = MUL_HL;
        state_next = ST_SEED_M2;
      end
      ST_SEED_M2: begin
        cmd.mulop  = MUL_LH;
        state_next = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.wrsel = WR_SEEDK;
        if (status.k_last) begin
          cmd.idxop   = IDX_SPENT;
          seeded_next = 1'b1;
          state_next  = pending ? ST_DRAW_CHECK : ST_IDLE;
        end else begin
          cmd.kop    = K_INC;
          state_next = ST_SEED_M0;
        end
      end
      ST_DRAW_CHECK: begin
        if (status.index_spent) begin
          cmd.kop    = K_ZERO;
          state_next = ST_TWIST_PRE;
        end else begin
          state_next = ST_DRAW_RD;
        end
      end
      ST_TWIST_PRE: begin
        cmd.rdsel  = RD_K;
        state_next = ST_TWIST_RD;
      end
      ST_TWIST_RD: begin
        cmd.rdsel  = RD_TWIST;
        state_next = ST_TWIST_WR;
      end
      ST_TWIST_WR: begin
        cmd.wrsel = WR_TWIST;
        if (status.k_last) begin
          cmd.idxop  = IDX_ZERO;
          state_next = ST_DRAW_RD;
        end else begin
          cmd.kop    = K_INC;
          state_next = ST_TWIST_RD;
        end
      end
      ST_DRAW_RD: begin
        cmd.rdsel  = RD_INDEX;
        state_next = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idxop    = IDX_INC;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/mt64_datapath.sv
// State memory, seed multiplier, twist and temper logic, and the result register.
module mt64_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mt64_pkg::WORD_W-1:0] seed_value,
  input  mt64_pkg::cmd_t              cmd,
  output mt64_pkg::status_t           status,
  mt64_out_if.source                  result,
  mt64_cfg_if.sink                    cfg
);
  import mt64_pkg::*;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v;
    t = t ^ ((t >> 29) & TEMPER_MASK_A);
    t = t ^ ((t << 17) & TEMPER_MASK_B);
    t = t ^ ((t << 37) & TEMPER_MASK_C);
    t = t ^ (t >> 43);
    return t;
  endfunction

  logic [WORD_W-1:0] mem [STATE_WORDS];
  logic [WORD_W-1:0] rd_a, rd_b;
  logic [WORD_W-1:0] default_seed;
  logic [WORD_W-1:0] seed_in;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] out_data;
  logic              out_valid;
  logic [ADDR_W-1:0] k, k_next;
  logic [ADDR_W-1:0] word_index, word_index_next;

  logic [WORD_W-1:0] seed_raw, seed_word, seed_next, y, twist_word, wr_data;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] prod;
  logic [ADDR_W-1:0] addr_a, addr_b, addr_w, k_plus1, k_offset;
  logic              rd_en_a, rd_en_b, wr_en, out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_seed <= FALLBACK_SEED;
    end else if (cfg.valid) begin
      default_seed <= cfg.default_seed;
    end
  end

  // seed source and fallback for zero
  assign seed_raw  = cmd.use_default ? default_seed : seed_in;
  assign seed_word = (seed_raw == '0) ? FALLBACK_SEED : seed_raw;
  assign seed_next = acc + WORD_W'(k);

  // one 32x32 partial product per cycle, low 64 bits of x * SEED_MULT
  assign mul_a = (cmd.mulop == MUL_HL) ? x[WORD_W-1:HALF_W] : x[HALF_W-1:0];
  assign mul_b = (cmd.mulop == MUL_LH) ? SEED_MULT[WORD_W-1:HALF_W] : SEED_MULT[HALF_W-1:0];
  assign prod  = WORD_W'(mul_a) * WORD_W'(mul_b);

  always_comb begin
    case (cmd.mulop)
      MUL_LL:  acc_next = prod;
      MUL_HL:  acc_next = acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      MUL_LH:  acc_next = acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      default: acc_next = acc;
    endcase
  end

  assign y          = (cur & UPPER_BITS) | (rd_a & LOWER_BITS);
  assign twist_word = rd_b ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);

  assign k_plus1  = (k == ADDR_W'(STATE_WORDS - 1)) ? '0 : k + ADDR_W'(1);
  assign k_offset = (k >= ADDR_W'(STATE_WORDS - TWIST_OFFSET)) ?
                    k - ADDR_W'(STATE_WORDS - TWIST_OFFSET) : k + ADDR_W'(TWIST_OFFSET);

  // the first seed word always lands at address zero
  assign addr_w = (cmd.wrsel == WR_SEED0) ? '0 : k;

  always_comb begin
    addr_a  = k;
    addr_b  = k_offset;
    rd_en_a = 1'b0;
    rd_en_b = 1'b0;
    case (cmd.rdsel)
      RD_K: begin
        rd_en_a = 1'b1;
      end
      RD_TWIST: begin
        addr_a  = k_plus1;
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
      end
      RD_INDEX: begin
        addr_a  = word_index;
        rd_en_a = 1'b1;
      end
      default: begin
        rd_en_a = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = twist_word;
    case (cmd.wrsel)
      WR_SEED0: wr_data = seed_word;
      WR_SEEDK: wr_data = seed_next;
      WR_TWIST: wr_data = twist_word;
      default:  wr_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_w] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a <= mem[addr_a];
    end
    if (rd_en_b) begin
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seed_in <= seed_value;
    end
    if (cmd.wrsel == WR_SEED0 || cmd.wrsel == WR_SEEDK) begin
      x <= wr_data ^ (wr_data >> 62);
    end
    if (cmd.rdsel == RD_TWIST) begin
      cur <= rd_a;
    end
    acc <= acc_next;
  end

  always_comb begin
    case (cmd.kop)
      K_ZERO:  k_next = '0;
      K_ONE:   k_next = ADDR_W'(1);
      K_INC:   k_next = k + ADDR_W'(1);
      default: k_next = k;
    endcase
    case (cmd.idxop)
      IDX_SPENT: word_index_next = ADDR_W'(STATE_WORDS);
      IDX_ZERO:  word_index_next = '0;
      IDX_INC:   word_index_next = word_index + ADDR_W'(1);
      default:   word_index_next = word_index;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      word_index <= ADDR_W'(STATE_WORDS);
    end else begin
      k          <= k_next;
      word_index <= word_index_next;
    end
  end

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load && out_free) begin
      out_data <= temper(rd_a);
    end
  end

  assign result.valid        = out_valid;
  assign result.random_value = out_data;

  assign status.k_last      = (k == ADDR_W'(STATE_WORDS - 1));
  assign status.index_spent = (word_index >= ADDR_W'(STATE_WORDS));
  assign status.out_free    = out_free;

endmodule
